>>> sv/mpqf_pkg.sv
// Shared types, constants and pack/unpack helpers for the quad-float Mandelbrot block.
package mpqf_pkg;

	localparam int unsigned EXP_BIAS = 16383;
	localparam int unsigned FRAC_BITS = 112;
	localparam int unsigned JUSTIFY = 15;
	localparam logic [14:0] EXP_MASK = 15'h7FFF;
	localparam logic [31:0] NO_ESCAPE = 32'hFFFF_FFFF;
	localparam logic [31:0] LIMIT_RESET = 32'd1000;
	localparam logic [4:0] MUL_STEPS = 5'd16;
	localparam logic [7:0] MAX_ALIGN = 8'd128;

	// Unpacked value: sign, 32-bit signed exponent, significand with leading one at bit 127
	typedef struct packed {
		logic sign;
		logic signed [31:0] exp;
		logic [127:0] mant;
	} qval_t;

	typedef enum logic {
		OP_MUL,
		OP_ADD
	} fpu_op_t;

	typedef struct packed {
		logic start;
		fpu_op_t op;
	} fpu_req_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_MUL,
		FS_MUL_NORM,
		FS_ALIGN,
		FS_SUM,
		FS_NORM,
		FS_ROUND
	} fpu_state_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_ZX2,
		SQ_ZY2,
		SQ_MAG,
		SQ_NX1,
		SQ_NX2,
		SQ_XY,
		SQ_NY,
		SQ_OUT
	} seq_state_t;

	// binary128 word to unpacked form; zero and subnormal read as zero
	function automatic qval_t q_unpack(input logic [63:0] h, input logic [63:0] l);
		qval_t p;
		logic [14:0] eb;
		eb = h[62:48];
		p.sign = h[63];
		if (eb == '0) begin
			p.exp = '0;
			p.mant = '0;
		end else begin
			p.exp = $signed({17'd0, eb} - 32'(EXP_BIAS));
			p.mant = {1'b1, h[47:0], l, 15'd0};
		end
		return p;
	endfunction

	// unpacked form to binary128 word {high, low}; exponent wraps to 15 bits
	function automatic logic [127:0] q_pack(input qval_t p);
		logic [127:0] r;
		logic [14:0] eb;
		eb = p.exp[14:0] + 15'(EXP_BIAS);
		if (p.mant == '0) begin
			r = {p.sign, 127'd0};
		end else begin
			r = {p.sign, eb & EXP_MASK, p.mant[126:79], p.mant[78:15]};
		end
		return r;
	endfunction

endpackage

>>> sv/mpqf_if.sv
// Valid/ready stream interfaces for point requests and escape results.
interface mpqf_in_if;
	logic valid;
	logic ready;
	logic [63:0] c_real_low;
	logic [63:0] c_real_high;
	logic [63:0] c_imag_low;
	logic [63:0] c_imag_high;

	modport source (output valid, c_real_low, c_real_high, c_imag_low, c_imag_high,
		input ready);
	modport sink (input valid, c_real_low, c_real_high, c_imag_low, c_imag_high,
		output ready);
endinterface

interface mpqf_out_if;
	logic valid;
	logic ready;
	logic escaped;
	logic [31:0] iteration_count;
	logic [63:0] magnitude_sq_low;
	logic [63:0] magnitude_sq_high;

	modport source (output valid, escaped, iteration_count, magnitude_sq_low,
		magnitude_sq_high, input ready);
	modport sink (input valid, escaped, iteration_count, magnitude_sq_low,
		magnitude_sq_high, output ready);
endinterface

>>> sv/mpqf_fpu.sv
// Shared multi-cycle quad-float unit: 32x32 multiply-accumulate, align/add, normalize, round.
module mpqf_fpu (
	input  logic clk,
	input  logic arst_n,
	input  mpqf_pkg::fpu_req_t req,
	input  mpqf_pkg::qval_t a,
	input  mpqf_pkg::qval_t b,
	output mpqf_pkg::qval_t res,
	output logic done
);
	import mpqf_pkg::*;

	fpu_state_t state_q, state_d;
	qval_t a_q, b_q, res_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [63:0] prod_s1;
	logic [2:0] off_s1;
	logic [255:0] acc_q;
	logic [127:0] lm_q, rm_q, rman_q;
	logic rsign_q, rstk_q, sub_q;
	logic signed [31:0] rexp_q;

	logic a_zero, b_zero, trivial;
	logic [1:0] ia, jb;
	logic a_big;
	qval_t lq, rq;
	logic signed [31:0] diff;
	logic [7:0] dsh;
	logic [127:0] rm0, rm_sh;
	logic st;
	logic [127:0] sum;
	logic [112:0] keep;
	logic [113:0] keep_inc;
	logic rbit, stk, inc;

	assign a_zero = (a.mant == '0);
	assign b_zero = (b.mant == '0);
	assign trivial = a_zero || b_zero;
	assign ia = cnt_q[3:2];
	assign jb = cnt_q[1:0];

	// operand ordering and alignment
	always_comb begin
		a_big = (a_q.exp != b_q.exp) ? (a_q.exp > b_q.exp) : (a_q.mant >= b_q.mant);
		lq = a_big ? a_q : b_q;
		rq = a_big ? b_q : a_q;
		diff = lq.exp - rq.exp;
		rm0 = rq.mant >> 1;
		if (diff > 0) begin
			dsh = (diff >= 32'sd128) ? MAX_ALIGN : diff[7:0];
		end else begin
			dsh = '0;
		end
		st = |(rm0 & ~({128{1'b1}} << dsh));
		rm_sh = (rm0 >> dsh) | {127'd0, st};
	end

	assign sum = sub_q ? (lm_q - rm_q) : (lm_q + rm_q);

	// round to nearest even at 113 bits
	always_comb begin
		keep = rman_q[127:15];
		rbit = rman_q[14];
		stk = rstk_q || (rman_q[13:0] != '0);
		inc = rbit && (keep[0] || stk);
		keep_inc = {1'b0, keep} + {113'd0, inc};
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (req.start && !trivial) begin
					state_d = (req.op == OP_MUL) ? FS_MUL : FS_ALIGN;
				end
			end
			FS_MUL: begin
				if (cnt_q == MUL_STEPS) state_d = FS_MUL_NORM;
			end
			FS_MUL_NORM: state_d = FS_ROUND;
			FS_ALIGN: state_d = FS_SUM;
			FS_SUM: state_d = (sum == '0) ? FS_IDLE : FS_NORM;
			FS_NORM: begin
				if (rman_q[127]) state_d = FS_ROUND;
			end
			FS_ROUND: state_d = FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == FS_IDLE) && req.start && trivial)
				|| ((state_q == FS_SUM) && (sum == '0))
				|| (state_q == FS_ROUND);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			FS_IDLE: begin
				a_q <= a;
				b_q <= b;
				cnt_q <= '0;
				acc_q <= '0;
				rsign_q <= a.sign ^ b.sign;
				rexp_q <= a.exp + b.exp;
				if (req.start && trivial) begin
					if (req.op == OP_MUL) begin
						res_q <= '{sign: a.sign ^ b.sign, exp: '0, mant: '0};
					end else begin
						res_q <= a_zero ? b : a;
					end
				end
			end
			FS_MUL: begin
				if (cnt_q != MUL_STEPS) begin
					prod_s1 <= a_q.mant[{ia, 5'd0} +: 32] * b_q.mant[{jb, 5'd0} +: 32];
					off_s1 <= {1'b0, ia} + {1'b0, jb};
				end
				if (cnt_q != '0) begin
					acc_q <= acc_q + ({192'd0, prod_s1} << {off_s1, 5'd0});
				end
				cnt_q <= cnt_q + 5'd1;
			end
			FS_MUL_NORM: begin
				if (acc_q[255]) begin
					rman_q <= acc_q[255:128];
					rexp_q <= rexp_q + 32'sd1;
					rstk_q <= (acc_q[127:0] != '0);
				end else begin
					rman_q <= acc_q[254:127];
					rstk_q <= (acc_q[126:0] != '0);
				end
			end
			FS_ALIGN: begin
				lm_q <= lq.mant >> 1;
				rm_q <= rm_sh;
				sub_q <= lq.sign ^ rq.sign;
				rsign_q <= lq.sign;
				rexp_q <= lq.exp + 32'sd1;
			end
			FS_SUM: begin
				rman_q <= sum;
				rstk_q <= 1'b0;
				if (sum == '0) res_q <= '0;
			end
			FS_NORM: begin
				// leading-zero search: 16 bits at a time, then single bits
				if (!rman_q[127]) begin
					if (rman_q[127:112] == '0) begin
						rman_q <= rman_q << 16;
						rexp_q <= rexp_q - 32'sd16;
					end else begin
						rman_q <= rman_q << 1;
						rexp_q <= rexp_q - 32'sd1;
					end
				end
			end
			FS_ROUND: begin
				res_q.sign <= rsign_q;
				if (keep_inc[113]) begin
					res_q.exp <= rexp_q + 32'sd1;
					res_q.mant <= {keep_inc[113:1], 15'd0};
				end else begin
					res_q.exp <= rexp_q;
					res_q.mant <= {keep_inc[112:0], 15'd0};
				end
			end
			default: ;
		endcase
	end

	assign res = res_q;
	assign done = done_q;

endmodule

>>> sv/mandelbrot_pixel_quad_float.sv
// Escape-time sequencer for one point, running all arithmetic on the shared quad-float unit.
// Each full iteration runs three multiplies and four adds, one at a time on the one shared unit;
//   an escaping point ends after the escape check (two multiplies and an add);
//   a zero operand, or a zero sum in an add, cuts an operation short; one point in flight.
// Request ready only when idle, so a new point waits until the result has been taken.
// Reset: arst_n clears the sequencer and output valid, and loads the iteration limit with 1000.
module mandelbrot_pixel_quad_float (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	mpqf_in_if.sink pt,
	mpqf_out_if.source res
);
	import mpqf_pkg::*;

	seq_state_t state_q, state_d;
	logic [31:0] limit_q, n_q;
	logic issued_q;
	qval_t cx_q, cy_q, zx_q, zy_q, zx2_q, zy2_q, t_q, nx_q;
	logic esc_q;
	logic [31:0] cnt_out_q;
	logic [127:0] mag_out_q;

	fpu_req_t req;
	qval_t op_a, op_b, fres, two_zx, neg_zy2;
	logic fdone, esc, more;

	assign two_zx = (zx_q.mant == '0) ? '{sign: zx_q.sign, exp: '0, mant: '0}
		: '{sign: zx_q.sign, exp: zx_q.exp + 32'sd1, mant: zx_q.mant};
	assign neg_zy2 = '{sign: ~zy2_q.sign, exp: zy2_q.exp, mant: zy2_q.mant};

	// |z|^2 > 4 test
	assign esc = (fres.exp > 32'sd2)
		|| ((fres.exp == 32'sd2) && (fres.mant > {1'b1, 127'd0}));
	assign more = ({1'b0, n_q} + 33'd1) < {1'b0, limit_q};

	// operand select for the shared unit
	always_comb begin
		op_a = zx_q;
		op_b = zx_q;
		req.op = OP_ADD;
		unique case (state_q)
			SQ_ZX2: begin op_a = zx_q; op_b = zx_q; req.op = OP_MUL; end
			SQ_ZY2: begin op_a = zy_q; op_b = zy_q; req.op = OP_MUL; end
			SQ_MAG: begin op_a = zx2_q; op_b = zy2_q; end
			SQ_NX1: begin op_a = zx2_q; op_b = neg_zy2; end
			SQ_NX2: begin op_a = t_q; op_b = cx_q; end
			SQ_XY: begin op_a = two_zx; op_b = zy_q; req.op = OP_MUL; end
			SQ_NY: begin op_a = t_q; op_b = cy_q; end
			default: ;
		endcase
		req.start = !issued_q && (state_q != SQ_IDLE) && (state_q != SQ_OUT);
	end

	mpqf_fpu u_fpu (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.a(op_a),
		.b(op_b),
		.res(fres),
		.done(fdone)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (pt.valid) state_d = (limit_q == '0) ? SQ_OUT : SQ_ZX2;
			end
			SQ_ZX2: if (fdone) state_d = SQ_ZY2;
			SQ_ZY2: if (fdone) state_d = SQ_MAG;
			SQ_MAG: if (fdone) state_d = esc ? SQ_OUT : SQ_NX1;
			SQ_NX1: if (fdone) state_d = SQ_NX2;
			SQ_NX2: if (fdone) state_d = SQ_XY;
			SQ_XY: if (fdone) state_d = SQ_NY;
			SQ_NY: if (fdone) state_d = more ? SQ_ZX2 : SQ_OUT;
			SQ_OUT: if (res.ready) state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			issued_q <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else begin
			state_q <= state_d;
			if (fdone) begin
				issued_q <= 1'b0;
			end else if (req.start) begin
				issued_q <= 1'b1;
			end
			if (cfg_wr_en) limit_q <= cfg_wr_data;
		end
	end

	// iteration state and result capture
	always_ff @(posedge clk) begin
		unique case (state_q)
			SQ_IDLE: begin
				cx_q <= q_unpack(pt.c_real_high, pt.c_real_low);
				cy_q <= q_unpack(pt.c_imag_high, pt.c_imag_low);
				zx_q <= '0;
				zy_q <= '0;
				n_q <= '0;
				esc_q <= 1'b0;
				cnt_out_q <= NO_ESCAPE;
				mag_out_q <= '0;
			end
			SQ_ZX2: if (fdone) zx2_q <= fres;
			SQ_ZY2: if (fdone) zy2_q <= fres;
			SQ_MAG: begin
				if (fdone && esc) begin
					esc_q <= 1'b1;
					cnt_out_q <= n_q;
					mag_out_q <= q_pack(fres);
				end
			end
			SQ_NX1: if (fdone) t_q <= fres;
			SQ_NX2: if (fdone) nx_q <= fres;
			SQ_XY: if (fdone) t_q <= fres;
			SQ_NY: begin
				if (fdone) begin
					zx_q <= nx_q;
					zy_q <= fres;
					n_q <= n_q + 32'd1;
				end
			end
			default: ;
		endcase
	end

	assign pt.ready = (state_q == SQ_IDLE);
	assign res.valid = (state_q == SQ_OUT);
	assign res.escaped = esc_q;
	assign res.iteration_count = cnt_out_q;
	assign res.magnitude_sq_low = mag_out_q[63:0];
	assign res.magnitude_sq_high = mag_out_q[127:64];

endmodule

>>> sv/mpqf_chk.sv
// Port-level checker for the quad-float Mandelbrot block, bound to the top level.
module mpqf_chk (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic escaped,
	input logic [31:0] iteration_count,
	input logic [63:0] mag_lo,
	input logic [63:0] mag_hi
);
	import mpqf_pkg::*;

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one point at a time: no new request while a result is offered
	a_one_point: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request ready while result pending");

	// no escape reports the fixed count and zero magnitude
	a_no_esc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !escaped |-> iteration_count == NO_ESCAPE && mag_lo == '0 && mag_hi == '0)
		else $error("non-escape result fields wrong");

	// an escape count is always below the limit, so never the marker value
	a_esc_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && escaped |-> iteration_count != NO_ESCAPE)
		else $error("escape count equals marker");

endmodule

bind mandelbrot_pixel_quad_float mpqf_chk u_mpqf_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(pt.ready),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.escaped(res.escaped),
	.iteration_count(res.iteration_count),
	.mag_lo(res.magnitude_sq_low),
	.mag_hi(res.magnitude_sq_high)
);
